@@ rtl/fba_pkg.sv @@
// ----------------------------------------------------------------------------
// fba_pkg: shared definitions of the bitmap frame allocator
// Widths of the fixed fields, the default frame limit, the result layout and
// the status that the clear-bit search hands back.
// ----------------------------------------------------------------------------
package fba_pkg;

  // Width of the frame count register.
  localparam int unsigned CFG_W          = 13;
  // Reset value of the frame count register.
  localparam int unsigned CFG_RESET      = 4096;
  // Width of the frame number fields on the streams.
  localparam int unsigned FRAME_W        = 12;
  // Default number of frames that the bitmap can describe.
  localparam int unsigned MAX_FRAMES_DEF = 4096;
  // Bits per bitmap word and the width of a bit index within a word.
  localparam int unsigned WORD_W         = 32;
  localparam int unsigned BIT_W          = 5;

  // Request kinds carried in in_tuser.
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  // Input beat payload (in_tdata), lowest bit last in the declaration.
  typedef struct packed {
    logic [1:0]         pad;
    logic               supervisor;
    logic               writable;
    logic [FRAME_W-1:0] current_frame;
  } req_t;

  // Result beat payload (out_tdata), lowest bit last in the declaration.
  typedef struct packed {
    logic [6:0]         pad;
    logic               full_res;
    logic               user_access;
    logic               read_write;
    logic               present;
    logic [FRAME_W-1:0] frame;
    logic               updated;
  } res_t;

  // Outcome of the lowest-clear-bit search over one bitmap word.
  typedef struct packed {
    logic             any;
    logic [BIT_W-1:0] idx;
  } find_t;

endpackage

@@ rtl/fba_ram.sv @@
// ----------------------------------------------------------------------------
// fba_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered, so it
// appears in the cycle after the address.
// ----------------------------------------------------------------------------
module fba_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/fba_lowclr.sv @@
// ----------------------------------------------------------------------------
// fba_lowclr: lowest clear bit of a bitmap word
// A priority encoder that finds the first free frame within one word.
// ----------------------------------------------------------------------------
module fba_lowclr (
  input  logic [fba_pkg::WORD_W-1:0] word,
  output fba_pkg::find_t             find
);

  // Scan from the top down so that the lowest clear bit wins.
  always_comb begin
    find.any = 1'b0;
    find.idx = '0;
    for (int i = fba_pkg::WORD_W - 1; i >= 0; i--) begin
      if (!word[i]) begin
        find.any = 1'b1;
        find.idx = fba_pkg::BIT_W'(i);
      end
    end
  end

endmodule

@@ rtl/bitmap_frame_allocator.sv @@
// ----------------------------------------------------------------------------
// bitmap_frame_allocator: first-fit page frame allocator
// Keeps one used bit per physical frame in a RAM and serves allocate and
// free requests for page entries, one request at a time.
// ----------------------------------------------------------------------------
// The used-frame bitmap lives in a RAM of ceil(MAX_FRAMES/32) words of 32
// bits. After reset a clearing pass writes every word to zero, one word a
// cycle; no request is taken until it ends, though frame_count may be
// written. An allocation reads the bitmap one word a cycle from word 0,
// pipelined behind the RAM's registered read, and stops at the first word
// with a clear bit below the frame limit. Allocations for an entry that
// already holds a frame, and frees of an entry with no frame, go straight
// to the result state; any other free reads the word, clears the bit and
// writes it back in the following cycle. A finished result sits in an
// output register until taken, and the next request is accepted only once
// the block has moved its result into that register.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator #(
  parameter int unsigned MAX_FRAMES = fba_pkg::MAX_FRAMES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // Request stream. in_tdata: current_frame[11:0], writable, supervisor.
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [15:0]               in_tdata,
  // in_tuser: func (0 allocate, 1 free).
  input  logic                      in_tuser,
  // Result stream. out_tdata: updated, frame[11:0], present, read_write,
  // user_access, full_res.
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [23:0]               out_tdata,
  // Frame count register.
  input  logic                      cfg_we,
  input  logic [fba_pkg::CFG_W-1:0] cfg_wdata
);

  localparam int unsigned WORDS   = (MAX_FRAMES + 31) / 32;
  localparam int unsigned WADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned LIM_W   = $clog2(MAX_FRAMES + 1);
  localparam int unsigned BASE_W  = WADDR_W + fba_pkg::BIT_W;
  localparam int unsigned CMP_A   = (LIM_W > BASE_W) ? LIM_W : BASE_W;
  localparam int unsigned CMP_W   = (CMP_A > fba_pkg::CFG_W) ? CMP_A : fba_pkg::CFG_W;
  localparam logic [WADDR_W-1:0] LAST_WORD = WADDR_W'(WORDS - 1);
  localparam logic [CMP_W-1:0]   MAX_C     = CMP_W'(MAX_FRAMES);

  // Sequencer states.
  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_SCAN = 3'd2;
  localparam logic [2:0] ST_FREE = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0]                  state_r, state_nxt;
  logic [WADDR_W-1:0]          clr_r, clr_nxt;
  logic [WADDR_W-1:0]          chk_r, chk_nxt;
  logic [fba_pkg::CFG_W-1:0]   frame_count_r;
  logic [CMP_W-1:0]            limit_r, limit_nxt;
  fba_pkg::req_t               req_r, req_nxt;
  fba_pkg::res_t               res_r, res_nxt;
  logic                        out_tvalid_r, out_tvalid_nxt;
  fba_pkg::res_t               out_tdata_r, out_tdata_nxt;

  fba_pkg::req_t               req_in;
  logic                        in_beat;
  logic [CMP_W-1:0]            cur_c, cur_q, fc_c, base_c, found_c;
  logic [WADDR_W-1:0]          cur_word_in, cur_word_q;

  logic                        ram_we;
  logic [WADDR_W-1:0]          ram_waddr, ram_raddr;
  logic [fba_pkg::WORD_W-1:0]  ram_wdata, ram_rdata;
  fba_pkg::find_t              find;

  // Bitmap storage.
  fba_ram #(
    .WIDTH (fba_pkg::WORD_W),
    .DEPTH (WORDS)
  ) u_bitmap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // First free frame in the word now leaving the RAM.
  fba_lowclr u_lowclr (
    .word (ram_rdata),
    .find (find)
  );

  assign req_in      = fba_pkg::req_t'(in_tdata);
  assign in_tready   = (state_r == ST_IDLE);
  assign in_beat     = in_tvalid && in_tready;
  assign cur_c       = CMP_W'(req_in.current_frame);
  assign cur_q       = CMP_W'(req_r.current_frame);
  assign cur_word_in = WADDR_W'(cur_c >> fba_pkg::BIT_W);
  assign cur_word_q  = WADDR_W'(cur_q >> fba_pkg::BIT_W);
  assign fc_c        = CMP_W'(frame_count_r);
  assign base_c      = CMP_W'({chk_r, fba_pkg::BIT_W'(0)});
  assign found_c     = base_c | CMP_W'(find.idx);

  assign out_tvalid  = out_tvalid_r;
  assign out_tdata   = out_tdata_r;

  // Request sequencer: clearing pass, dispatch, scan, free write-back, result.
  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    chk_nxt        = chk_r;
    limit_nxt      = limit_r;
    req_nxt        = req_r;
    res_nxt        = res_r;
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    ram_we         = 1'b0;
    ram_waddr      = chk_r;
    ram_wdata      = ram_rdata;
    ram_raddr      = (chk_r == LAST_WORD) ? chk_r : chk_r + WADDR_W'(1);

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + WADDR_W'(1);
        if (clr_r == LAST_WORD) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        ram_raddr = (in_tuser == fba_pkg::FUNC_FREE) ? cur_word_in : '0;
        if (in_beat) begin
          req_nxt   = req_in;
          res_nxt   = '0;
          chk_nxt   = '0;
          limit_nxt = (fc_c > MAX_C) ? MAX_C : fc_c;
          state_nxt = ST_EMIT;
          if (in_tuser == fba_pkg::FUNC_ALLOC) begin
            if (req_in.current_frame == '0) begin
              state_nxt = ST_SCAN;
            end
          end else if (req_in.current_frame != '0) begin
            res_nxt.updated = 1'b1;
            if (cur_c < MAX_C) begin
              state_nxt = ST_FREE;
            end
          end
        end
      end
      ST_SCAN: begin
        // The word for chk_r arrives now while the next one is read.
        chk_nxt = chk_r + WADDR_W'(1);
        if (base_c >= limit_r) begin
          res_nxt.full_res = 1'b1;
          state_nxt        = ST_EMIT;
        end else if (find.any) begin
          state_nxt = ST_EMIT;
          if (found_c < limit_r) begin
            ram_we              = 1'b1;
            ram_waddr           = chk_r;
            ram_wdata           = ram_rdata | (fba_pkg::WORD_W'(1) << find.idx);
            res_nxt.updated     = 1'b1;
            res_nxt.frame       = found_c[fba_pkg::FRAME_W-1:0];
            res_nxt.present     = 1'b1;
            res_nxt.read_write  = req_r.writable;
            res_nxt.user_access = ~req_r.supervisor;
          end else begin
            res_nxt.full_res = 1'b1;
          end
        end else if (chk_r == LAST_WORD) begin
          res_nxt.full_res = 1'b1;
          state_nxt        = ST_EMIT;
        end
      end
      ST_FREE: begin
        // Write back the word read in the dispatch cycle with the bit cleared.
        ram_we    = 1'b1;
        ram_waddr = cur_word_q;
        ram_wdata = ram_rdata &
                    ~(fba_pkg::WORD_W'(1) << req_r.current_frame[fba_pkg::BIT_W-1:0]);
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = res_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLR;
      clr_r         <= '0;
      out_tvalid_r  <= 1'b0;
      frame_count_r <= fba_pkg::CFG_W'(fba_pkg::CFG_RESET);
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_we) begin
        frame_count_r <= cfg_wdata;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    chk_r       <= chk_nxt;
    limit_r     <= limit_nxt;
    req_r       <= req_nxt;
    res_r       <= res_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  // A bitmap write during a scan always ends the scan.
  a_scan_write_ends : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) && ram_we |=> (state_r == ST_EMIT))
    else $error("bitmap written during scan without finishing the request");

  // A new result beat only ever comes out of the result state.
  a_result_source : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> ($past(state_r) == ST_EMIT))
    else $error("result beat raised outside the result state");

  // The scan never runs past the last bitmap word.
  a_scan_bound : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (chk_r <= LAST_WORD))
    else $error("scan pointer beyond the bitmap");

endmodule

@@ sim/bitmap_frame_allocator_test.sv @@
// ----------------------------------------------------------------------------
// bitmap_frame_allocator_test: self-checking bench for the frame allocator
// Drives allocate and free requests through the request stream, keeps its
// own copy of the used-frame bitmap and the frame limit, and compares each
// result beat field by field with the expected page entry update, predicted
// or taken from the table. A short table of directed requests comes first,
// then random phases under several frame limits and idling patterns.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LIMIT_CYCLES = 2000000;
  localparam int unsigned LONG_HOLD    = 500;
  localparam int unsigned N_DIRECTED   = 21;
  localparam int unsigned N_PHASES     = 9;

  typedef enum logic {ROW_REQUEST, ROW_SET_LIMIT} row_kind_t;
  typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  // One directed step: a request, or a new frame limit. Where checked is set
  // the result fields are given here rather than predicted.
  typedef struct packed {
    row_kind_t                   kind;
    logic                        func;
    logic [fba_pkg::FRAME_W-1:0] cur;
    logic                        wr;
    logic                        sup;
    logic                        checked;
    logic                        w_upd;
    logic [fba_pkg::FRAME_W-1:0] w_frame;
    logic                        w_pres;
    logic                        w_rw;
    logic                        w_usr;
    logic                        w_full;
    logic [fba_pkg::CFG_W-1:0]   limit;
  } step_t;

  localparam step_t DIRECTED_ROWS [N_DIRECTED] = '{
    // Frame zero is handed out first; then frame 1 with the opposite flags.
    '{ROW_REQUEST,   fba_pkg::FUNC_ALLOC, 12'd0,    1'b1, 1'b0, 1'b1,
      1'b1, 12'd0, 1'b1, 1'b1, 1'b1, 1'b0, 13'd0},
    '{ROW_REQUEST,   fba_pkg::FUNC_ALLOC, 12'd0,    1'b0, 1'b1, 1'b1,
      1'b1, 12'd1, 1'b1, 1'b0, 1'b0, 1'b0, 13'd0},
    // Entry already holds a frame, and a free of an entry with none.
    '{ROW_REQUEST,   fba_pkg::FUNC_ALLOC, 12'd4095, 1'b1, 1'b1, 1'b1,
      1'b0, 12'd0, 1'b0, 1'b0, 1'b0, 1'b0, 13'd0},
    '{ROW_REQUEST,   fba_pkg::FUNC_FREE,  12'd0,    1'b1, 1'b1, 1'b1,
      1'b0, 12'd0, 1'b0, 1'b0, 1'b0, 1'b0, 13'd0},
    // Free of a frame that is already clear, then a real free.
    '{ROW_REQUEST,   fba_pkg::FUNC_FREE,  12'd4095, 1'b0, 1'b0, 1'b1,
      1'b1, 12'd0, 1'b0, 1'b0, 1'b0, 1'b0, 13'd0},
    '{ROW_REQUEST,   fba_pkg::FUNC_FREE,  12'd1,    1'b1, 1'b0, 1'b1,
      1'b1, 12'd0, 1'b0, 1'b0, 1'b0, 1'b0, 13'd0},
    '{ROW_REQUEST,   fba_pkg::FUNC_ALLOC, 12'd0,    1'b1, 1'b1, 1'b0,
      1'b0, 12'd0, 1'b0, 1'b0, 1'b0, 1'b0, 13'd0},
    '{ROW_REQUEST,   fba_pkg::FUNC_ALLOC, 12'd0,    1'b0, 1'b0, 1'b0,
      1'b0, 12'd0, 1'b0, 1'b0, 1'b0, 1'b0, 13'd0},
    // Every frame below the limit taken: the allocator reports full.
    '{ROW_SET_LIMIT, fba_pkg::FUNC_ALLOC, 12'd0,    1'b0, 1'b0, 1'b0,
      1'b0, 12'd0, 1'b0, 1'b0, 1'b0, 1'b0, 13'd3},
    '{ROW_REQUEST,   fba_pkg::FUNC_ALLOC, 12'd0,    1'b1, 1'b0, 1'b1,
      1'b0, 12'd0, 1'b0, 1'b0, 1'b0, 1'b1, 13'd0},
    '{ROW_SET_LIMIT, fba_pkg::FUNC_ALLOC, 12'd0,    1'b0, 1'b0, 1'b0,
      1'b0, 12'd0, 1'b0, 1'b0, 1'b0, 1'b0, 13'd0},
    '{ROW_REQUEST,   fba_pkg::FUNC_ALLOC, 12'd0,    1'b1, 1'b0, 1'b1,
      1'b0, 12'd0, 1'b0, 1'b0, 1'b0, 1'b1, 13'd0},
    '{ROW_REQUEST,   fba_pkg::FUNC_FREE,  12'd2,    1'b0, 1'b1, 1'b1,
      1'b1, 12'd0, 1'b0, 1'b0, 1'b0, 1'b0, 13'd0},
    // A limit above the bitmap size saturates.
    '{ROW_SET_LIMIT, fba_pkg::FUNC_ALLOC, 12'd0,    1'b0, 1'b0, 1'b0,
      1'b0, 12'd0, 1'b0, 1'b0, 1'b0, 1'b0, 13'd8191},
    '{ROW_REQUEST,   fba_pkg::FUNC_ALLOC, 12'd0,    1'b1, 1'b0, 1'b0,
      1'b0, 12'd0, 1'b0, 1'b0, 1'b0, 1'b0, 13'd0},
    '{ROW_REQUEST,   fba_pkg::FUNC_ALLOC, 12'h800,  1'b0, 1'b0, 1'b1,
      1'b0, 12'd0, 1'b0, 1'b0, 1'b0, 1'b0, 13'd0},
    '{ROW_REQUEST,   fba_pkg::FUNC_FREE,  12'hAAA,  1'b1, 1'b0, 1'b1,
      1'b1, 12'd0, 1'b0, 1'b0, 1'b0, 1'b0, 13'd0},
    '{ROW_REQUEST,   fba_pkg::FUNC_FREE,  12'h555,  1'b0, 1'b1, 1'b1,
      1'b1, 12'd0, 1'b0, 1'b0, 1'b0, 1'b0, 13'd0},
    '{ROW_SET_LIMIT, fba_pkg::FUNC_ALLOC, 12'd0,    1'b0, 1'b0, 1'b0,
      1'b0, 12'd0, 1'b0, 1'b0, 1'b0, 1'b0, 13'd4096},
    '{ROW_REQUEST,   fba_pkg::FUNC_ALLOC, 12'd0,    1'b0, 1'b1, 1'b0,
      1'b0, 12'd0, 1'b0, 1'b0, 1'b0, 1'b0, 13'd0},
    '{ROW_REQUEST,   fba_pkg::FUNC_FREE,  12'd3,    1'b1, 1'b1, 1'b0,
      1'b0, 12'd0, 1'b0, 1'b0, 1'b0, 1'b0, 13'd0}
  };

  // Random phases: frame limit, idling pattern and number of requests.
  localparam int unsigned PHASE_LIMIT [N_PHASES] = '{4096, 40, 8191, 100, 33, 1, 0, 300, 4096};
  localparam idle_mode_t  PHASE_IDLE  [N_PHASES] = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER,
                                                     IDLE_BOTH, IDLE_NONE, IDLE_SENDER,
                                                     IDLE_RECEIVER, IDLE_BOTH, IDLE_NONE};
  localparam int unsigned PHASE_ITEMS [N_PHASES] = '{150, 150, 150, 150, 150, 100, 50, 200,
                                                     150};
  localparam int unsigned HOLD_PHASE  = 3;
  localparam int unsigned PAUSE_PHASE = 4;

  logic                      clk;
  logic                      rst_n      = 1'b0;
  logic                      in_tvalid  = 1'b0;
  logic                      in_tready;
  logic [15:0]               in_tdata   = '0;
  logic                      in_tuser   = 1'b0;
  logic                      out_tvalid;
  logic                      out_tready = 1'b0;
  logic [23:0]               out_tdata;
  logic                      cfg_we     = 1'b0;
  logic [fba_pkg::CFG_W-1:0] cfg_wdata  = '0;

  // Predictor state: used bit per frame, the frame limit, and the frames
  // handed out so far that random frees can give back.
  bit [fba_pkg::MAX_FRAMES_DEF-1:0] frame_in_use;
  int unsigned                      frame_limit = fba_pkg::CFG_RESET;
  int unsigned                      held_frames[$];
  fba_pkg::res_t                    pending_updates[$];

  int unsigned sender_idle_pct   = 0;
  int unsigned receiver_stall_pct = 0;
  logic        holding_off       = 1'b0;
  int unsigned mismatches        = 0;
  int unsigned cycle_count       = 0;

  bitmap_frame_allocator u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("bitmap_frame_allocator verification failed");
      $finish;
    end
  end

  // Page entry update that a request should produce; it also moves the
  // predictor's bitmap along.
  function automatic fba_pkg::res_t next_entry_update(logic func,
                                                      logic [fba_pkg::FRAME_W-1:0] cur,
                                                      logic wr, logic sup);
    fba_pkg::res_t upd;
    int unsigned   scan_end;
    bit            found;
    int            hit[$];
    upd = '0;
    if (func == fba_pkg::FUNC_ALLOC) begin
      if (cur == '0) begin
        scan_end = (frame_limit > fba_pkg::MAX_FRAMES_DEF) ? fba_pkg::MAX_FRAMES_DEF :
                   frame_limit;
        found = 1'b0;
        for (int unsigned f = 0; f < scan_end && !found; f++) begin
          if (!frame_in_use[f]) begin
            found           = 1'b1;
            frame_in_use[f] = 1'b1;
            upd.updated     = 1'b1;
            upd.frame       = f[fba_pkg::FRAME_W-1:0];
            upd.present     = 1'b1;
            upd.read_write  = wr;
            upd.user_access = ~sup;
            // Frame zero cannot be given back, since zero means no frame.
            if (f != 0) held_frames.push_back(f);
          end
        end
        upd.full_res = !found;
      end
    end else if (cur != '0) begin
      frame_in_use[cur] = 1'b0;
      upd.updated = 1'b1;
      hit = held_frames.find_first_index(x) with (x == cur);
      if (hit.size() != 0) held_frames.delete(hit[0]);
    end
    return upd;
  endfunction

  // Offers one request beat and records its expected update on acceptance.
  task automatic offer_request(logic func, logic [fba_pkg::FRAME_W-1:0] cur, logic wr,
                               logic sup, bit checked, fba_pkg::res_t table_update);
    fba_pkg::req_t req;
    fba_pkg::res_t predicted;
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    req               = '0;
    req.current_frame = cur;
    req.writable      = wr;
    req.supervisor    = sup;
    in_tvalid <= 1'b1;
    in_tdata  <= req;
    in_tuser  <= func;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = next_entry_update(func, cur, wr, sup);
    pending_updates.push_back(checked ? table_update : predicted);
  endtask

  // Stops offering and waits until every expected update has come back.
  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    while (pending_updates.size() != 0) @(posedge clk);
  endtask

  // Writes the frame limit once the block has gone idle.
  task automatic set_frame_limit(logic [fba_pkg::CFG_W-1:0] value);
    wait_for_results();
    // Let a trailing bitmap write-back settle.
    repeat (8) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we      <= 1'b0;
    frame_limit = 32'(value);
  endtask

  // The long receiver hold-off, counted here so the sender keeps going.
  initial begin
    forever begin
      @(posedge clk);
      if (holding_off) begin
        repeat (LONG_HOLD) @(posedge clk);
        holding_off <= 1'b0;
      end
    end
  end

  // Result side: check each accepted beat, then decide the next ready.
  always @(posedge clk) begin : take_results
    fba_pkg::res_t got;
    fba_pkg::res_t want;
    if (out_tvalid && out_tready) begin
      got = out_tdata;
      if (pending_updates.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result beat with nothing expected: %h", out_tdata);
      end else begin
        want = pending_updates.pop_front();
        if (got.updated !== want.updated || got.frame !== want.frame ||
            got.present !== want.present || got.read_write !== want.read_write ||
            got.user_access !== want.user_access || got.full_res !== want.full_res) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: expected upd=%0b frame=%0d pres=%0b rw=%0b user=%0b ",
                      "full=%0b, got upd=%0b frame=%0d pres=%0b rw=%0b user=%0b full=%0b"},
                     want.updated, want.frame, want.present, want.read_write,
                     want.user_access, want.full_res, got.updated, got.frame, got.present,
                     got.read_write, got.user_access, got.full_res);
        end
      end
    end
    if (holding_off) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
  end

  // Main sequence: reset, directed table, random phases, drain.
  initial begin
    step_t         row;
    fba_pkg::res_t table_update;
    logic          func;
    logic [11:0]   cur;
    int unsigned   pick;
    frame_in_use = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED_ROWS[i]) begin
      row = DIRECTED_ROWS[i];
      if (row.kind == ROW_SET_LIMIT) begin
        set_frame_limit(row.limit);
      end else begin
        table_update             = '0;
        table_update.updated     = row.w_upd;
        table_update.frame       = row.w_frame;
        table_update.present     = row.w_pres;
        table_update.read_write  = row.w_rw;
        table_update.user_access = row.w_usr;
        table_update.full_res    = row.w_full;
        offer_request(row.func, row.cur, row.wr, row.sup, row.checked, table_update);
      end
    end

    for (int p = 0; p < N_PHASES; p++) begin
      set_frame_limit(fba_pkg::CFG_W'(PHASE_LIMIT[p]));
      case (PHASE_IDLE[p])
        IDLE_NONE: begin
          sender_idle_pct = 0;
          receiver_stall_pct = 0;
        end
        IDLE_SENDER: begin
          sender_idle_pct = 50;
          receiver_stall_pct = 0;
        end
        IDLE_RECEIVER: begin
          sender_idle_pct = 0;
          receiver_stall_pct = 50;
        end
        default: begin
          sender_idle_pct = 15;
          receiver_stall_pct = 15;
        end
      endcase
      if (p == HOLD_PHASE) holding_off <= 1'b1;

      for (int n = 0; n < PHASE_ITEMS[p]; n++) begin
        pick = $urandom_range(0, 99);
        // Mostly well-formed traffic: allocate into empty entries and give
        // back frames that were handed out; the rest is odd requests.
        if (pick < 55) begin
          func = fba_pkg::FUNC_ALLOC;
          cur  = '0;
        end else if (pick < 85 && held_frames.size() != 0) begin
          func = fba_pkg::FUNC_FREE;
          cur  = 12'(held_frames[$urandom_range(0, held_frames.size() - 1)]);
        end else if (pick < 90) begin
          func = fba_pkg::FUNC_ALLOC;
          cur  = 12'($urandom_range(1, 4095));
        end else if (pick < 95) begin
          func = fba_pkg::FUNC_FREE;
          cur  = 12'($urandom_range(0, 4095));
        end else begin
          func = 1'($urandom_range(0, 1));
          cur  = 12'($urandom_range(0, 4095));
        end
        offer_request(func, cur, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0,
                      '0);
        if (p == PAUSE_PHASE && n % 40 == 39) wait_for_results();
      end
    end

    wait_for_results();
    repeat (20) @(posedge clk);
    if (mismatches == 0)
      $display("bitmap_frame_allocator verification clean");
    else
      $display("bitmap_frame_allocator verification failed");
    $finish;
  end

endmodule
